>>> rtl/rfpd_pkg.sv
// Shared types, codes and the CRC byte update for the RF packet decoder.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package rfpd_pkg;

  localparam int unsigned PKT_BYTES_DEF = 32;
  localparam int unsigned DATA_MAX_DEF  = 27;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;
  localparam logic [7:0]  SRC_MASK = 8'h0F;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACK_MASK = 2'd0,
    CFG_STATUS_CMD = 2'd1,
    CFG_VERSION_CMD = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] ACK_MASK_RST = 8'h80;

  typedef enum logic [1:0] {
    ST_CMD_OK  = 2'd0,
    ST_RESP_OK = 2'd1,
    ST_CRC_ERR = 2'd2,
    ST_LEN_ERR = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    status_e           status;
    logic [4:0]        src_id;
    logic [7:0]        command_code;
    logic signed [7:0] argument;
    logic [4:0]        data_count;
    logic [7:0]        data_byte;
    logic              data_valid;
    logic              last;
  } res_item_t;

  // CRC-16-CCITT, MSB first, one byte per call
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rfpd_if.sv
// Valid/ready channel interfaces: received bytes in, decoded results out.
// Depends on rfpd_pkg for the payload types.
`default_nettype none

interface rfpd_rx_if import rfpd_pkg::*; ();
  logic     valid;
  logic     ready;
  rx_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfpd_res_if import rfpd_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rf_packet_decoder.sv
// RF packet decoder top level: byte store, CRC check, classification, result emit.
// Depends on rfpd_pkg and the rfpd_rx_if / rfpd_res_if channel interfaces.
// Usage:
//   rx_if carries one received byte per request; packets are PACKET_BYTES long,
//   the last two bytes being the CRC (low byte first). Position is counted here,
//   so the sender just streams bytes. While a packet is coming in, one byte is
//   taken every cycle. Body bytes go into a single-port store RAM.
//   After the final byte, results leave on res_if through one output register:
//   - CRC error, command, plain response or length error: one request, loaded
//     into the output register from S_SINGLE once the register is free.
//   - status/version response with N data bytes: N requests, each a RAM read
//     in S_FETCH followed by a load in S_HOLD once the output register is free.
//   rx_if.ready is low from the final byte until the last result of that packet
//   is loaded into the output register. The RAM read port sets the burst rate,
//   and a stalled receiver slows it further.
//   A stalled receiver holds the output register; the block keeps accepting the
//   next packet's bytes as long as it is not itself in an emit phase.
//   Reset (rst_ni low) returns the position to zero, the CRC to 0xFFFF and the
//   registers to their defaults; the store RAM is not cleared (every packet
//   overwrites it before it is read). Config writes belong between packets.
`default_nettype none

module rf_packet_decoder import rfpd_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PKT_BYTES_DEF,
  parameter int unsigned DATA_MAX     = DATA_MAX_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  rfpd_rx_if.sink                rx_if,
  rfpd_res_if.source             res_if,
  input  wire                    cfg_we_i,
  input  wire [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned BODY  = PACKET_BYTES - 2;
  localparam int unsigned AW    = $clog2(BODY);
  localparam int unsigned PW    = $clog2(PACKET_BYTES);
  localparam int unsigned KW    = $clog2(DATA_MAX + 1);
  localparam int unsigned IW    = $clog2(DATA_MAX + 3);
  localparam logic [PW-1:0] POS_LAST  = PW'(PACKET_BYTES - 1);
  localparam logic [PW-1:0] POS_CRCLO = PW'(BODY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_FETCH,
    S_HOLD
  } state_e;

  // configuration
  logic [7:0] ack_mask_q, status_cmd_q, version_cmd_q;

  // receive side
  state_e        state_q;
  logic [PW-1:0] pos_q;
  logic [15:0]   crc_q;
  logic [7:0]    crc_lo_q;
  logic [7:0]    b0_q, b1_q, b2_q;

  // decoded packet summary
  status_e           dec_st_q;
  logic [4:0]        dec_src_q;
  logic [7:0]        dec_cmd_q;
  logic signed [7:0] dec_arg_q;
  logic [KW-1:0]     n_q, k_q;

  // store RAM
  logic [7:0] mem_q [BODY];
  logic [7:0] rdata_q;
  logic       oob_q;

  // output register
  logic      out_valid_q;
  res_item_t out_q;

  logic rx_acc, out_free, final_byte, crc_ok, is_resp, has_data;
  logic out_load, burst_start;
  logic [IW-1:0] rd_idx;
  logic          rd_in_range;
  logic [4:0]    src;

  assign rx_if.ready = (state_q == S_IDLE);
  assign rx_acc      = rx_if.valid && rx_if.ready;
  assign final_byte  = rx_acc && (pos_q == POS_LAST);
  assign out_free    = !out_valid_q || res_if.ready;
  assign out_load    = ((state_q == S_SINGLE) || (state_q == S_HOLD)) && out_free;
  assign res_if.valid = out_valid_q;
  assign res_if.data  = out_q;

  assign crc_ok   = ({rx_if.data.rx_byte, crc_lo_q} == crc_q);
  assign is_resp  = ((b0_q & ack_mask_q) == ack_mask_q);
  assign has_data = (b1_q == status_cmd_q) || (b1_q == version_cmd_q);
  assign src      = 5'(b0_q & SRC_MASK) + 5'd1;
  // good status/version response with a data count in 1..DATA_MAX
  assign burst_start = crc_ok && is_resp && has_data && (b2_q != 8'h00) &&
                       (b2_q <= 8'(DATA_MAX));

  // data byte k sits at packet byte 3+k; past the body it reads as zero
  assign rd_idx      = IW'(k_q) + IW'(3);
  assign rd_in_range = (7'(rd_idx) < 7'(BODY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_mask_q    <= ACK_MASK_RST;
      status_cmd_q  <= 8'h00;
      version_cmd_q <= 8'h00;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACK_MASK:    ack_mask_q    <= cfg_data_i;
        CFG_STATUS_CMD:  status_cmd_q  <= cfg_data_i;
        CFG_VERSION_CMD: version_cmd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // single-port store: written on body bytes, read only during the data burst
  always_ff @(posedge clk_i) begin
    if (rx_acc && (pos_q < POS_CRCLO)) begin
      mem_q[pos_q[AW-1:0]] <= rx_if.data.rx_byte;
    end
    if (state_q == S_FETCH && rd_in_range) begin
      rdata_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      crc_q       <= CRC_INIT;
      crc_lo_q    <= 8'h00;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (rx_acc) begin
            if (pos_q < POS_CRCLO) begin
              crc_q <= crc16_feed(crc_q, rx_if.data.rx_byte);
              pos_q <= pos_q + PW'(1);
              if (pos_q == PW'(0)) b0_q <= rx_if.data.rx_byte;
              if (pos_q == PW'(1)) b1_q <= rx_if.data.rx_byte;
              if (pos_q == PW'(2)) b2_q <= rx_if.data.rx_byte;
            end else if (pos_q == POS_CRCLO) begin
              crc_lo_q <= rx_if.data.rx_byte;
              pos_q    <= pos_q + PW'(1);
            end else begin
              // final byte: check and classify
              pos_q <= '0;
              crc_q <= CRC_INIT;
              k_q   <= '0;
              n_q   <= KW'(b2_q);
              state_q <= burst_start ? S_FETCH : S_SINGLE;
              if (!crc_ok) begin
                dec_st_q  <= ST_CRC_ERR;
                dec_src_q <= 5'd0;
                dec_cmd_q <= 8'h00;
                dec_arg_q <= 8'sh00;
              end else if (!is_resp) begin
                dec_st_q  <= ST_CMD_OK;
                dec_src_q <= 5'd0;
                dec_cmd_q <= b0_q;
                dec_arg_q <= b1_q;
              end else begin
                dec_src_q <= src;
                dec_cmd_q <= b1_q;
                dec_arg_q <= b2_q;
                if (has_data && (b2_q > 8'(DATA_MAX))) begin
                  dec_st_q <= ST_LEN_ERR;
                end else begin
                  dec_st_q <= ST_RESP_OK;
                end
              end
            end
          end
        end
        S_SINGLE: begin
          if (out_free) begin
            out_q.status       <= dec_st_q;
            out_q.src_id       <= dec_src_q;
            out_q.command_code <= dec_cmd_q;
            out_q.argument     <= dec_arg_q;
            out_q.data_count   <= 5'd0;
            out_q.data_byte    <= 8'h00;
            out_q.data_valid   <= 1'b0;
            out_q.last         <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        S_FETCH: begin
          oob_q   <= !rd_in_range;
          state_q <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            out_q.status       <= dec_st_q;
            out_q.src_id       <= dec_src_q;
            out_q.command_code <= dec_cmd_q;
            out_q.argument     <= dec_arg_q;
            out_q.data_count   <= 5'(n_q);
            out_q.data_byte    <= oob_q ? 8'h00 : rdata_q;
            out_q.data_valid   <= 1'b1;
            out_q.last         <= (k_q == n_q - KW'(1));
            k_q                <= k_q + KW'(1);
            state_q            <= (k_q == n_q - KW'(1)) ? S_IDLE : S_FETCH;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_final_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_byte |=> state_q != S_IDLE)
    else $error("final byte did not start result emission");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_LAST)
    else $error("byte position beyond packet length");

  a_burst_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH || state_q == S_HOLD) |-> (k_q < n_q))
    else $error("data burst index past data length");

  a_hold_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_HOLD))
    else $error("RAM read data not consumed in hold state");
`endif

endmodule

`default_nettype wire

>>> tb/rfpd_sb_pkg.sv
// Scoreboard for the RF packet decoder testbench: byte-level decode predictor and result checker.
// Depends on rfpd_pkg for the result type, status codes, register indexes and CRC constants.
`timescale 1ns / 1ps

package rfpd_sb_pkg;
  import rfpd_pkg::*;

  localparam int unsigned BODY_N = PKT_BYTES_DEF - 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // CRC-16-CCITT, MSB first, bit-serial form
  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  class decode_scoreboard;
    logic [7:0]  ack_mask;
    logic [7:0]  status_code;
    logic [7:0]  version_code;
    logic [5:0]  byte_pos;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    logic [7:0]  body [BODY_N];
    res_item_t   expected_q [$];
    int          errors;
    int          issued;

    function new();
      ack_mask     = ACK_MASK_RST;
      status_code  = 8'h00;
      version_code = 8'h00;
      byte_pos     = '0;
      crc          = CRC_INIT;
      crc_lo       = 8'h00;
      errors       = 0;
      issued       = 0;
      foreach (body[i]) body[i] = 8'h00;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_ACK_MASK:    ack_mask = v;
        CFG_STATUS_CMD:  status_code = v;
        CFG_VERSION_CMD: version_code = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] body_at(int unsigned idx);
      return (idx < BODY_N) ? body[idx] : 8'h00;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(res_item_t r);
      expected_q.push_back(r);
      issued++;
    endfunction

    // one accepted byte; results only on the final (CRC high) byte
    function void note_byte(logic [7:0] b);
      res_item_t   r;
      logic [7:0]  b0, b1, b2;
      int unsigned n;
      if (byte_pos < BODY_N) begin
        body[byte_pos] = b;
        crc = crc_next(crc, b);
        byte_pos++;
        return;
      end
      if (byte_pos == BODY_N) begin
        crc_lo = b;
        byte_pos++;
        return;
      end
      byte_pos = '0;
      r = '0;
      r.last = 1'b1;
      if ({b, crc_lo} != crc) begin
        crc = CRC_INIT;
        r.status = ST_CRC_ERR;
        push(r);
        return;
      end
      crc = CRC_INIT;
      b0 = body_at(0);
      b1 = body_at(1);
      b2 = body_at(2);
      if ((b0 & ack_mask) != ack_mask) begin
        r.status       = ST_CMD_OK;
        r.command_code = b0;
        r.argument     = b1;
        push(r);
        return;
      end
      r.src_id       = {1'b0, 4'(b0 & SRC_MASK)} + 5'd1;
      r.command_code = b1;
      r.argument     = b2;
      r.status       = ST_RESP_OK;
      if (b1 != status_code && b1 != version_code) begin
        push(r);
        return;
      end
      n = b2;
      if (n > DATA_MAX_DEF) begin
        r.status = ST_LEN_ERR;
        push(r);
        return;
      end
      if (n == 0) begin
        push(r);
        return;
      end
      for (int unsigned k = 0; k < n; k++) begin
        r.data_count  = 5'(n);
        r.data_byte   = body_at(3 + k);
        r.data_valid  = 1'b1;
        r.last        = (k + 1 == n);
        push(r);
      end
    endfunction

    function bit field_ok(string fname, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, seen);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      bit        ok;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      ok = 1'b1;
      ok &= field_ok("status", want.status, got.status);
      ok &= field_ok("src_id", want.src_id, got.src_id);
      ok &= field_ok("command_code", want.command_code, got.command_code);
      ok &= field_ok("argument", {24'b0, want.argument}, {24'b0, got.argument});
      ok &= field_ok("data_count", want.data_count, got.data_count);
      ok &= field_ok("data_byte", want.data_byte, got.data_byte);
      ok &= field_ok("data_valid", want.data_valid, got.data_valid);
      ok &= field_ok("last", want.last, got.last);
      if (!ok) errors++;
    endfunction
  endclass

endpackage

>>> tb/rf_packet_decoder_tb.sv
// Top-level testbench for rf_packet_decoder: drives packets byte by byte, checks every result.
// Depends on rfpd_pkg, the rfpd channel interfaces, rfpd_sb_pkg and the decoder RTL.
`timescale 1ns / 1ps

module rf_packet_decoder_tb;
  import rfpd_pkg::*;
  import rfpd_sb_pkg::*;

  // ways of closing a packet
  localparam int CRC_GOOD   = 0;
  localparam int CRC_BAD_LO = 1;
  localparam int CRC_BAD_HI = 2;
  localparam int CRC_RANDOM = 3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rfpd_rx_if  rx_if ();
  rfpd_res_if res_if ();

  rf_packet_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_if      (rx_if),
    .res_if     (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  decode_scoreboard sb = new();

  // percent chance per cycle that the sender idles / the receiver stalls
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // body of the packet under construction (bytes 0 .. PACKET_BYTES-3)
  logic [7:0] body_buf [BODY_N];

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Result side: values read right after the edge are the ones the edge saw,
  // so valid/ready here are the handshake of that edge.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Run limit: far above the slowest legal run (every packet a 27-result
  // burst under heavy stall).
  initial begin
    #5_000_000;
    $display("rf_packet_decoder_tb: done, errors");
    $finish;
  end

  // One request on rx. valid stays high across back-to-back requests; it is
  // only lowered inside a gap, so each step sees a single assignment to it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid        <= 1'b1;
    rx_if.data.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    sb.note_byte(b);
  endtask

  // Bytes 0..2 given, the rest a constant or random (fill < 0).
  task automatic fill_body(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input int fill);
    foreach (body_buf[i]) body_buf[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    body_buf[0] = b0;
    body_buf[1] = b1;
    body_buf[2] = b2;
  endtask

  // Sends body_buf followed by the CRC, low byte first, optionally spoiled.
  task automatic send_packet(input int crc_mode);
    logic [15:0] c;
    logic [7:0]  lo, hi;
    c = CRC_INIT;
    foreach (body_buf[i]) c = crc_next(c, body_buf[i]);
    lo = c[7:0];
    hi = c[15:8];
    case (crc_mode)
      CRC_BAD_LO: lo = lo ^ 8'($urandom_range(1, 255));
      CRC_BAD_HI: hi = hi ^ 8'($urandom_range(1, 255));
      CRC_RANDOM: {hi, lo} = 16'($urandom);
      default: ;
    endcase
    foreach (body_buf[i]) send_byte(body_buf[i]);
    send_byte(lo);
    send_byte(hi);
  endtask

  // Idle the sender and wait until every predicted result is back, then wait
  // longer so the emit logic has surely gone quiet.
  task automatic drain();
    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes all three registers plus the unused index (must be ignored).
  // cfg_we_i stays high through the burst and drops once at the end.
  task automatic apply_config(input logic [7:0] mask, input logic [7:0] st,
                              input logic [7:0] ver);
    logic [7:0]           vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    vals = '{mask, st, ver, 8'($urandom)};
    idxs = '{CFG_ACK_MASK, CFG_STATUS_CMD, CFG_VERSION_CMD, CFG_IDX_UNUSED};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni             <= 1'b0;
    rx_if.valid        <= 1'b0;
    rx_if.data         <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_ACK_MASK;
    cfg_data_i         <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // four packets, one per idling pattern, one per status code

    // no idling, reset registers: all-zero command, argument -128
    send_idle_pct = 0;  stall_pct = 0;
    fill_body(8'h00, 8'h80, 8'h00, 8'h00);
    send_packet(CRC_GOOD);
    drain();

    // sender mostly idle: CRC mismatch in the high byte
    send_idle_pct = 88; stall_pct = 0;
    fill_body(8'h85, 8'h00, 8'h02, -1);
    send_packet(CRC_BAD_HI);
    drain();

    // receiver mostly stalled: longest status data burst
    send_idle_pct = 0;  stall_pct = 88;
    fill_body(8'h8A, 8'h00, 8'(DATA_MAX_DEF), -1);
    send_packet(CRC_GOOD);
    drain();

    // both idling, mask zero so everything is a response; count too large
    send_idle_pct = 31; stall_pct = 31;
    apply_config(8'h00, 8'h5A, 8'hFF);
    fill_body(8'h33, 8'h5A, 8'(DATA_MAX_DEF + 1), -1);
    send_packet(CRC_GOOD);
    drain();

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rf_packet_decoder_tb: done, clean");
    end else begin
      $display("rf_packet_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
